### design/salct_pkg.sv
// Shared types and constants for the set-associative LRU cache tracker.
// Holds the controller state type, the controller/datapath command and status
// structs, register indexes and field widths. No dependencies.
`timescale 1ns / 1ps

package salct_pkg;

   // Parameter defaults.
   localparam int DEF_MAX_SET_BITS = 6;
   localparam int DEF_MAX_WAYS     = 8;
   localparam int DEF_COUNT_WIDTH  = 32;

   // Request and response field widths.
   localparam int ADDR_W   = 64;
   localparam int TAG_W    = 62;
   localparam int TOTAL_W  = 32;
   localparam int FLAG_CNT = 4;
   localparam int RSP_W    = 104;

   // Configuration port.
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 6;
   localparam int SB_CFG_W  = 3;
   localparam int BB_CFG_W  = 6;
   localparam int WAY_CFG_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_IN_USE = 2'd2;

   // Register values after reset.
   localparam int RST_SET_BITS    = 4;
   localparam int RST_BLOCK_BITS  = 4;
   localparam int RST_WAYS_IN_USE = 1;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } ctrl_state_type;

   typedef struct packed {
      logic load;    // accept a request and read its set row
      logic commit;  // write the row back, update totals, load the response
   } ctrl_cmd_type;

   typedef struct packed {
      logic rsp_free;  // response register empty or being drained this cycle
   } dp_status_type;

endpackage

### design/salct_ctrl.sv
// Controller for the cache tracker: a two-state machine that sequences the
// set-row read and the write-back. Depends on salct_pkg.
`timescale 1ns / 1ps

module salct_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output salct_pkg::ctrl_cmd_type cmd,
   input  salct_pkg::dp_status_type status
);
   import salct_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_LOOKUP: begin
            cmd.commit = status.rsp_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // An accepted request always moves on to its lookup.
   a_load_to_lookup: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_LOOKUP))
      else $error("load did not enter lookup");

   // A lookup blocked by a full response register keeps its place.
   a_lookup_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP && !status.rsp_free) |=> (state_ff == ST_LOOKUP))
      else $error("lookup left while response was blocked");

   // After its write-back the controller is ready for the next request.
   a_commit_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (state_ff == ST_IDLE))
      else $error("write-back did not return to idle");

endmodule

### design/salct_dp.sv
// Datapath for the cache tracker: geometry registers, the per-set row memory,
// hit/fill/LRU selection, saturating totals and the response register.
// Depends on salct_pkg.
`timescale 1ns / 1ps

module salct_dp #(
   parameter int MAX_SET_BITS = salct_pkg::DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = salct_pkg::DEF_MAX_WAYS,
   parameter int COUNT_WIDTH  = salct_pkg::DEF_COUNT_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [salct_pkg::ADDR_W-1:0]       req_addr,
   input  logic                               req_modify,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [salct_pkg::RSP_W-1:0]        rsp_tdata,
   input  logic                               csr_wen,
   input  logic [salct_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [salct_pkg::CSR_W-1:0]        csr_wdata,
   input  salct_pkg::ctrl_cmd_type            cmd,
   output salct_pkg::dp_status_type           status
);
   import salct_pkg::*;

   localparam int NUM_SETS = 2 ** MAX_SET_BITS;
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int RANK_W   = WAY_W;
   localparam int SB_W     = $clog2(MAX_SET_BITS + 1);
   localparam int WAYS_W   = $clog2(MAX_WAYS + 1);
   localparam int SHIFT_W  = 7;
   localparam int SB_RST   = (RST_SET_BITS > MAX_SET_BITS) ? MAX_SET_BITS : RST_SET_BITS;
   localparam int WAYS_RST = (RST_WAYS_IN_USE > MAX_WAYS) ? MAX_WAYS : RST_WAYS_IN_USE;
   localparam int PAD_W    = RSP_W - FLAG_CNT - 3 * TOTAL_W;

   typedef struct packed {
      logic [MAX_WAYS-1:0]              valid;
      logic [MAX_WAYS-1:0][TAG_W-1:0]   tag;
      logic [MAX_WAYS-1:0][RANK_W-1:0]  rank;
   } row_type;

   // Geometry, already clamped to legal values.
   logic [SB_W-1:0]     sb_ff, sb_in;
   logic [BB_CFG_W-1:0] bb_ff, bb_in;
   logic [WAYS_W-1:0]   ways_ff, ways_in;

   row_type                 line_mem [NUM_SETS];
   row_type                 rd_row_ff;
   logic                    rd_row_vld_ff;
   logic [NUM_SETS-1:0]     row_vld_ff, row_vld_in;
   logic [MAX_SET_BITS-1:0] set_ff;
   logic [TAG_W-1:0]        tag_ff;
   logic                    modify_ff;

   logic [COUNT_WIDTH-1:0]  hit_cnt_ff, hit_cnt_in;
   logic [COUNT_WIDTH-1:0]  miss_cnt_ff, miss_cnt_in;
   logic [COUNT_WIDTH-1:0]  evict_cnt_ff, evict_cnt_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]        rsp_data_ff, rsp_data_in;

   logic [MAX_SET_BITS-1:0] set_idx;
   logic [TAG_W-1:0]        tag_new;
   logic                    hit;
   logic                    miss;
   logic                    evict;
   row_type                 wr_row;

   //------------------------------------------------------------------
   // Configuration writes. A write to a listed register clears the store and the totals.
   //------------------------------------------------------------------
   always_comb begin
      logic [SB_CFG_W-1:0]  sb_raw;
      logic [WAY_CFG_W-1:0] ways_raw;
      sb_raw   = csr_wdata[SB_CFG_W-1:0];
      ways_raw = csr_wdata[WAY_CFG_W-1:0];
      sb_in    = sb_ff;
      bb_in    = bb_ff;
      ways_in  = ways_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_SET_BITS: begin
               if (sb_raw == '0) begin
                  sb_in = SB_W'(1);
               end else if (int'(sb_raw) > MAX_SET_BITS) begin
                  sb_in = SB_W'(MAX_SET_BITS);
               end else begin
                  sb_in = SB_W'(sb_raw);
               end
            end
            CSR_BLOCK_BITS: begin
               bb_in = (csr_wdata[BB_CFG_W-1:0] == '0) ? BB_CFG_W'(1)
                                                       : csr_wdata[BB_CFG_W-1:0];
            end
            CSR_WAYS_IN_USE: begin
               if (ways_raw == '0) begin
                  ways_in = WAYS_W'(1);
               end else if (int'(ways_raw) > MAX_WAYS) begin
                  ways_in = WAYS_W'(MAX_WAYS);
               end else begin
                  ways_in = WAYS_W'(ways_raw);
               end
            end
            default: begin
               sb_in = sb_ff;
            end
         endcase
      end
   end

   // A write to an index past the register list changes nothing.
   logic cfg_clear;
   assign cfg_clear = csr_wen && (csr_index == CSR_SET_BITS || csr_index == CSR_BLOCK_BITS ||
                                  csr_index == CSR_WAYS_IN_USE);

   //------------------------------------------------------------------
   // Address split at acceptance.
   //------------------------------------------------------------------
   always_comb begin
      logic [ADDR_W-1:0]       shifted;
      logic [MAX_SET_BITS-1:0] mask;
      logic [SHIFT_W-1:0]      shift_sum;
      logic [ADDR_W-1:0]       tag_full;
      shifted   = req_addr >> bb_ff;
      mask      = ~({MAX_SET_BITS{1'b1}} << sb_ff);
      set_idx   = shifted[MAX_SET_BITS-1:0] & mask;
      shift_sum = SHIFT_W'(sb_ff) + SHIFT_W'(bb_ff);
      tag_full  = (shift_sum >= SHIFT_W'(ADDR_W)) ? '0 : (req_addr >> shift_sum);
      tag_new   = tag_full[TAG_W-1:0];
   end

   // Row memory: one row per set holds every way.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rd_row_ff <= line_mem[set_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         line_mem[set_ff] <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         set_ff        <= set_idx;
         tag_ff        <= tag_new;
         modify_ff     <= req_modify;
         rd_row_vld_ff <= row_vld_ff[set_idx];
      end
   end

   //------------------------------------------------------------------
   // Lookup, victim choice and recency update on the row read back.
   //------------------------------------------------------------------
   always_comb begin
      logic [MAX_WAYS-1:0]             in_use;
      logic [MAX_WAYS-1:0]             vld;
      logic [MAX_WAYS-1:0]             match;
      logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
      logic                            free_found;
      logic [WAY_W-1:0]                hit_way;
      logic [WAY_W-1:0]                free_way;
      logic [WAY_W-1:0]                lru_way;
      logic [RANK_W-1:0]               oldest;
      logic [WAY_W-1:0]                target;
      logic                            tgt_valid;
      logic [RANK_W-1:0]               tgt_rank;
      hit        = 1'b0;
      free_found = 1'b0;
      hit_way    = '0;
      free_way   = '0;
      lru_way    = '0;
      oldest     = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use[w] = (WAYS_W'(w) < ways_ff);
         vld[w]    = rd_row_vld_ff && rd_row_ff.valid[w] && in_use[w];
         match[w]  = vld[w] && (rd_row_ff.tag[w] == tag_ff);
         rank[w]   = rd_row_vld_ff ? rd_row_ff.rank[w] : '0;
      end
      // Lowest-numbered way wins among matches and among free ways.
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (in_use[w] && !vld[w]) begin
            free_found = 1'b1;
            free_way   = WAY_W'(w);
         end
      end
      // Oldest line; on equal ranks the lower way stays.
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (in_use[w] && rank[w] > oldest) begin
            oldest  = rank[w];
            lru_way = WAY_W'(w);
         end
      end
      miss  = !hit;
      evict = !hit && !free_found;
      if (hit) begin
         target = hit_way;
      end else if (free_found) begin
         target = free_way;
      end else begin
         target = lru_way;
      end
      tgt_valid = hit || evict;
      tgt_rank  = rank[target];
      // Lines younger than the accessed one age by one; a fill ages all.
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (WAY_W'(w) == target) begin
            wr_row.valid[w] = 1'b1;
            wr_row.tag[w]   = tag_ff;
            wr_row.rank[w]  = '0;
         end else begin
            wr_row.valid[w] = rd_row_vld_ff && rd_row_ff.valid[w];
            wr_row.tag[w]   = rd_row_ff.tag[w];
            if (vld[w] && (!tgt_valid || rank[w] < tgt_rank)) begin
               wr_row.rank[w] = rank[w] + RANK_W'(1);
            end else begin
               wr_row.rank[w] = rank[w];
            end
         end
      end
   end

   //------------------------------------------------------------------
   // Saturating totals and the response register.
   //------------------------------------------------------------------
   always_comb begin
      logic [1:0]             hit_add;
      logic [COUNT_WIDTH:0]   hit_sum;
      logic [COUNT_WIDTH:0]   miss_sum;
      logic [COUNT_WIDTH:0]   evict_sum;
      hit_add   = {1'b0, hit} + {1'b0, modify_ff};
      hit_sum   = {1'b0, hit_cnt_ff} + (COUNT_WIDTH + 1)'(hit_add);
      miss_sum  = {1'b0, miss_cnt_ff} + (COUNT_WIDTH + 1)'(miss);
      evict_sum = {1'b0, evict_cnt_ff} + (COUNT_WIDTH + 1)'(evict);

      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      evict_cnt_in = evict_cnt_ff;
      row_vld_in   = row_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (cmd.commit) begin
         hit_cnt_in   = hit_sum[COUNT_WIDTH] ? '1 : hit_sum[COUNT_WIDTH-1:0];
         miss_cnt_in  = miss_sum[COUNT_WIDTH] ? '1 : miss_sum[COUNT_WIDTH-1:0];
         evict_cnt_in = evict_sum[COUNT_WIDTH] ? '1 : evict_sum[COUNT_WIDTH-1:0];
         row_vld_in[set_ff] = 1'b1;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{PAD_W{1'b0}},
                         TOTAL_W'(evict_cnt_in),
                         TOTAL_W'(miss_cnt_in),
                         TOTAL_W'(hit_cnt_in),
                         modify_ff, evict, miss, hit};
      end
      if (cfg_clear) begin
         hit_cnt_in   = '0;
         miss_cnt_in  = '0;
         evict_cnt_in = '0;
         row_vld_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_ff        <= SB_W'(SB_RST);
         bb_ff        <= BB_CFG_W'(RST_BLOCK_BITS);
         ways_ff      <= WAYS_W'(WAYS_RST);
         row_vld_ff   <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         evict_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sb_ff        <= sb_in;
         bb_ff        <= bb_in;
         ways_ff      <= ways_in;
         row_vld_ff   <= row_vld_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         evict_cnt_ff <= evict_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign status.rsp_free = !rsp_valid_ff || rsp_tready;

   // A write-back is only issued when the response register can take it.
   a_commit_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("commit while response register full");

   // A response shows exactly one of hit and miss.
   a_hit_xor_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot(rsp_data_ff[1:0]))
      else $error("response is not exactly one of hit and miss");

   // An eviction only ever comes with a miss.
   a_evict_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[2]) |-> rsp_data_ff[1])
      else $error("eviction reported without a miss");

endmodule

### design/set_assoc_lru_cache_tracker.sv
// Top level of the set-associative LRU cache tracker: joins the controller
// and the datapath. Depends on salct_pkg, salct_ctrl and salct_dp.
`timescale 1ns / 1ps
//
//   Channel   Direction  Handshake              Payload
//   req       in         req_tvalid/req_tready  tdata: address; tuser: is_modify
//   rsp       out        rsp_tvalid/rsp_tready  tdata: flags and running totals
//   csr       in         csr_wen (no wait)      csr_index, csr_wdata
//
// For each request, the acceptance cycle reads the set's row from
// the single-ported row memory, and the next cycle compares all ways in
// parallel and writes the row back. A new request is taken the cycle after the
// write-back, so requests are handled one at a time.
// Reset (synchronous, active high) and writes to configuration registers clear
// the totals and a per-set valid flag, so no clearing pass over the memory is
// needed. While the response register still holds an untaken response, a
// finished lookup waits with its write-back until the register drains.

module set_assoc_lru_cache_tracker #(
   parameter int MAX_SET_BITS = salct_pkg::DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = salct_pkg::DEF_MAX_WAYS,
   parameter int COUNT_WIDTH  = salct_pkg::DEF_COUNT_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [salct_pkg::ADDR_W-1:0]    req_tdata,   // [63:0] address
   input  logic                            req_tuser,   // [0] is_modify
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] hit, [1] miss, [2] eviction, [3] is_modify, [35:4] hit_total,
   // [67:36] miss_total, [99:68] eviction_total, [103:100] zero
   output logic [salct_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                            csr_wen,
   input  logic [salct_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [salct_pkg::CSR_W-1:0]     csr_wdata
);
   import salct_pkg::*;

   // Commands from the controller and the datapath's back-pressure status.
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The controller only sequences the read and the write-back of one row.
   salct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // The datapath holds the geometry, the row memory, the totals and the
   // response register.
   salct_dp #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_addr   (req_tdata),
      .req_modify (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
